/* rtl/ruf_pkg.sv */
// ----------------------------------------------------------------------------
// ruf_pkg
// Types, codes and defaults shared by the resource unit flow allocator.
// ----------------------------------------------------------------------------
package ruf_pkg;

    // Fixed field widths
    localparam int TASK_W    = 10;
    localparam int RES_W     = 2;
    localparam int CAP_W     = 7;
    localparam int NUM_CFG   = 4;
    localparam int CFG_IDX_W = 2;

    // Parameter defaults
    localparam int DEF_NUM_RESOURCES = 4;
    localparam int DEF_MAX_UNITS     = 64;
    localparam int DEF_MAX_TASKS     = 1024;

    localparam logic       CMD_CLAIM   = 1'b0;
    localparam logic       CMD_RESTART = 1'b1;
    localparam logic [6:0] CAP_RESET   = 7'd1;

    typedef struct packed {
        logic              cmd;
        logic [TASK_W-1:0] task_id;
        logic [RES_W-1:0]  resource_index;
        logic [CAP_W-1:0]  demand;
    } t_in_word;

    typedef struct packed {
        logic [TASK_W-1:0] provider_task;
        logic [TASK_W-1:0] consumer_task;
        logic              last;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_RUN,
        S_FLUSH
    } t_ctl_state;

    // Controller to datapath
    typedef struct packed {
        logic reseed;
        logic load;
        logic start;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_restart;
        logic claim_ok;
        logic step_ok;
        logic last_unit;
        logic pend_valid;
        logic out_free;
    } t_dp_status;

endpackage

/* rtl/ruf_ctrl.sv */
// ----------------------------------------------------------------------------
// ruf_ctrl
// Sequencer for one claim: setup, one unit per step, final arc flush.
// ----------------------------------------------------------------------------
module ruf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ruf_pkg::t_dp_status i_status,
    output ruf_pkg::t_dp_cmd    o_cmd
);
    import ruf_pkg::*;

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_status.in_restart) begin
                        o_cmd.reseed = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                if (i_status.claim_ok) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (i_status.step_ok) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_unit) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                // hold until the pending arc, if any, goes out as the last one
                o_cmd.finish = 1'b1;
                if (!i_status.pend_valid || i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ruf_datapath.sv */
// ----------------------------------------------------------------------------
// ruf_datapath
// Unit owner RAM, per-pool ring heads and fill counts, arc merge and output
// register.
// ----------------------------------------------------------------------------
module ruf_datapath #(
    parameter int NUM_RESOURCES = ruf_pkg::DEF_NUM_RESOURCES,
    parameter int MAX_UNITS     = ruf_pkg::DEF_MAX_UNITS,
    parameter int MAX_TASKS     = ruf_pkg::DEF_MAX_TASKS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ruf_pkg::t_in_word                i_in_data,
    input  logic                             i_cfg_we,
    input  logic [ruf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ruf_pkg::CAP_W-1:0]        i_cfg_wdata,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output ruf_pkg::t_out_word               o_out_data,
    input  ruf_pkg::t_dp_cmd                 i_cmd,
    output ruf_pkg::t_dp_status              o_status
);
    import ruf_pkg::*;

    localparam int HW    = $clog2(MAX_UNITS + 1);
    localparam int HDW   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
    localparam int DEPTH = NUM_RESOURCES * MAX_UNITS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;

    logic [CAP_W-1:0]  r_cap [NUM_CFG];
    logic [TASK_W-1:0] mem [DEPTH];
    logic [TASK_W-1:0] r_rd_data;

    // A pool is written from slot zero upward, so the written slots are
    // always a prefix whose length is the fill count.
    logic [HW-1:0]     r_fill     [NUM_RESOURCES];
    logic [HDW-1:0]    r_head_pool[NUM_RESOURCES];

    logic [TASK_W-1:0] r_task;
    logic [RES_W-1:0]  r_res;
    logic [CAP_W-1:0]  r_demand;
    logic [HDW-1:0]    r_head;
    logic [HW-1:0]     r_left;
    logic [TASK_W-1:0] r_prev;
    logic              r_have_prev;
    logic              r_pend_valid;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic [RW-1:0]     res_idx;
    logic              res_ok;
    logic              task_ok;
    logic [CAP_W-1:0]  cfg_cap;
    logic [HW-1:0]     cap;
    logic [HW-1:0]     need;
    logic [HDW-1:0]    head0;
    logic [HW-1:0]     head_inc;
    logic [HDW-1:0]    head_next;
    logic [AW-1:0]     base;
    logic [AW-1:0]     slot;
    logic [AW-1:0]     rd_addr;
    logic              slot_used;
    logic              emit;
    logic              out_free;
    logic              push_mid;
    logic              push_last;

    always_comb begin
        res_idx  = RW'(r_res);
        res_ok   = int'(r_res) < NUM_RESOURCES;
        task_ok  = int'(r_task) < MAX_TASKS;
        // every 2-bit resource index has a capacity register
        cfg_cap  = r_cap[r_res];
        cap      = (int'(cfg_cap) > MAX_UNITS) ? HW'(MAX_UNITS) : HW'(cfg_cap);
        need     = (int'(r_demand) > int'(cap)) ? cap : HW'(r_demand);
        head0    = (HW'(r_head_pool[res_idx]) >= cap) ? '0 : r_head_pool[res_idx];
        head_inc = HW'(r_head) + HW'(1);
        head_next = (head_inc >= cap) ? '0 : HDW'(head_inc);
        base     = AW'(int'(r_res) * MAX_UNITS);
        slot     = base + AW'(r_head);
        slot_used = HW'(r_head) < r_fill[res_idx];
        emit     = slot_used && (!r_have_prev || (r_rd_data != r_prev));
        out_free = !r_out_valid || !i_out_stall;
        push_mid = i_cmd.step && emit && r_pend_valid;
        push_last = i_cmd.finish && r_pend_valid && out_free;

        if (i_cmd.start) begin
            rd_addr = base + AW'(head0);
        end else if (i_cmd.step) begin
            rd_addr = base + AW'(head_next);
        end else begin
            rd_addr = slot;
        end
    end

    always_comb begin
        o_status.in_restart = (i_in_data.cmd == CMD_RESTART);
        o_status.claim_ok   = res_ok && task_ok && (need != '0);
        o_status.step_ok    = !(emit && r_pend_valid && !out_free);
        o_status.last_unit  = (r_left == HW'(1));
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = out_free;
    end

    // Owner RAM: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            mem[slot] <= r_task;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CFG; i++) begin
                r_cap[i] <= CAP_RESET;
            end
        end else if (i_cfg_we) begin
            r_cap[i_cfg_idx] <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reseed) begin
            for (int i = 0; i < NUM_RESOURCES; i++) begin
                r_fill[i]      <= '0;
                r_head_pool[i] <= '0;
            end
        end else begin
            if (i_cmd.step && !slot_used) begin
                r_fill[res_idx] <= head_inc;
            end
            if (i_cmd.finish) begin
                r_head_pool[res_idx] <= r_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_task   <= i_in_data.task_id;
            r_res    <= i_in_data.resource_index;
            r_demand <= i_in_data.demand;
        end
        if (i_cmd.start) begin
            r_head <= head0;
            r_left <= need;
        end else if (i_cmd.step) begin
            r_head <= head_next;
            r_left <= r_left - HW'(1);
            if (emit) begin
                r_prev <= r_rd_data;
            end
        end
        if (push_mid) begin
            r_out_word <= '{provider_task: r_prev, consumer_task: r_task, last: 1'b0};
        end else if (push_last) begin
            r_out_word <= '{provider_task: r_prev, consumer_task: r_task, last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_have_prev  <= 1'b0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.step && emit) begin
                r_have_prev  <= 1'b1;
                r_pend_valid <= 1'b1;
            end else if (push_last) begin
                r_pend_valid <= 1'b0;
            end
            if (push_mid || push_last) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

endmodule

/* rtl/resource_unit_flow_allocator.sv */
// ----------------------------------------------------------------------------
// resource_unit_flow_allocator
// Per-resource unit pools; claims take units earliest released first and
// emit merged (provider, consumer) arcs.
// ----------------------------------------------------------------------------
//  channel  dir  signals                              carries
//  in       in   i_in_valid  o_in_stall  i_in_data    claim or restart word
//  out      out  o_out_valid i_out_stall o_out_data   arc word
//  cfg      in   i_cfg_we    i_cfg_idx   i_cfg_wdata  pool capacity
//
//  A claim of d units takes min(d, capacity) units, one unit per cycle unless
//  the output stalls, through the owner RAM (one read and one write a cycle),
//  plus setup and flush. A restart is taken in idle; an ignored claim ends at setup.
//  Reset and restart empty every pool at once by clearing the fill counts.
//  A stalled output holds the claim at the next arc that must go out.
// ----------------------------------------------------------------------------
module resource_unit_flow_allocator #(
    parameter int NUM_RESOURCES = ruf_pkg::DEF_NUM_RESOURCES,
    parameter int MAX_UNITS     = ruf_pkg::DEF_MAX_UNITS,
    parameter int MAX_TASKS     = ruf_pkg::DEF_MAX_TASKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ruf_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ruf_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [ruf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ruf_pkg::CAP_W-1:0]     i_cfg_wdata
);
    import ruf_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    ruf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    ruf_datapath #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .MAX_UNITS     (MAX_UNITS),
        .MAX_TASKS     (MAX_TASKS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status)
    );

endmodule
